FILE: design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FFBA_ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define FFBA_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: design/ffba_pkg.sv
// ============================================================================
// ffba_pkg
// Types, constants and transaction formats of the first-fit block allocator.
// ============================================================================
package ffba_pkg;

   // Default heap size in blocks and the fixed block size in bytes.
   localparam int HEAP_BLOCKS_DEF = 1024;
   localparam int BLOCK_BYTES     = 8;
   localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);

   // Field widths of the transactions.
   localparam int REQ_BYTES_W = 13;
   localparam int KIND_W      = 4;
   localparam int HANDLE_W    = 10;
   localparam int STATUS_W    = 2;
   localparam int MERGED_W    = 10;

   // Width of a block count for one allocation (bytes / BLOCK_BYTES + 1).
   localparam int NEED_W = $clog2(((1 << REQ_BYTES_W) - 1) / BLOCK_BYTES + 2);

   // Request actions.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SUPP = 2'd3;

   // Kind tag of a free header, and the tag used when an allocate gives none.
   localparam logic [KIND_W-1:0] KIND_FREE    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_DEFAULT = 4'd1;

   typedef struct packed {
      logic                   action;
      logic [REQ_BYTES_W-1:0] request_bytes;
      logic [KIND_W-1:0]      block_kind;
      logic [HANDLE_W-1:0]    handle;
      logic                   frees_suppressed;
   } ffba_req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] granted_handle;
      logic [STATUS_W-1:0] status;
      logic [MERGED_W-1:0] merged_blocks;
   } ffba_rsp_type;

   // Control from the top level to the engine.
   typedef struct packed {
      logic start;
      logic slot_free;
   } ffba_ctl_type;

   // Status from the engine to the top level.
   typedef struct packed {
      logic ready;
      logic done;
   } ffba_sts_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_A_WALK,
      S_A_SPLIT,
      S_F_HEAD,
      S_F_WALK,
      S_F_FINAL,
      S_DONE
   } ffba_state_type;

endpackage

FILE: design/ffba_engine.sv
// ============================================================================
// ffba_engine
// Header memory and the sequencer that walks the header chain for allocate
// and free transactions, one header read per cycle.
// ============================================================================
module ffba_engine #(
   parameter int HEAP_BLOCKS = ffba_pkg::HEAP_BLOCKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ffba_pkg::ffba_req_type req,
   input  ffba_pkg::ffba_ctl_type ctl,
   output ffba_pkg::ffba_sts_type sts,
   output ffba_pkg::ffba_rsp_type res
);
   import ffba_pkg::*;

   localparam int AW = $clog2(HEAP_BLOCKS);
   localparam int PW = (AW + 1 > NEED_W + 1) ? AW + 1 : NEED_W + 1;
   localparam int WW = 1 + KIND_W + AW;
   localparam logic [PW-1:0] HEAP_END = PW'(HEAP_BLOCKS);
   localparam logic [AW-1:0] LAST_IDX = AW'(HEAP_BLOCKS - 1);

   // Header memory: {mark, kind, length} per block.
   logic [WW-1:0] heap_mem [HEAP_BLOCKS];
   logic [WW-1:0] rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   ffba_state_type state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     walk_ff, walk_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [AW-1:0]     len_ff, len_in;
   logic [AW:0]       extra_ff, extra_in;
   ffba_rsp_type      res_ff, res_in;

   logic              rd_mark;
   logic [KIND_W-1:0] rd_kind;
   logic [AW-1:0]     rd_len;
   logic [NEED_W-1:0] need_now;
   logic [PW-1:0]     hdr_now;
   logic              hdr_bad;
   logic              fits;
   logic              splits;
   logic [PW-1:0]     hop_pos;
   logic [PW-1:0]     hop_walk;
   logic [PW-1:0]     split_pos;
   logic [AW:0]       extra_sum;
   logic              absorb;

   // Memory ports, read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= heap_mem[rd_addr];
      end
   end

   // Fields of the header that was read last cycle.
   assign rd_mark = rd_data_ff[WW-1];
   assign rd_kind = rd_data_ff[AW +: KIND_W];
   assign rd_len  = rd_data_ff[AW-1:0];

   // Decoded request and chain arithmetic.
   assign need_now  = NEED_W'(req.request_bytes >> BLOCK_SHIFT) + NEED_W'(1);
   assign hdr_now   = PW'(req.handle) - PW'(1);
   assign hdr_bad   = (req.handle == '0) || (hdr_now >= HEAP_END);
   assign fits      = (rd_kind == KIND_FREE) && (PW'(rd_len) >= PW'(need_ff));
   assign split_pos = pos_ff + PW'(need_ff) + PW'(1);
   assign splits    = (PW'(rd_len) > PW'(need_ff)) && (split_pos < HEAP_END);
   assign hop_pos   = pos_ff + PW'(rd_len) + PW'(1);
   assign hop_walk  = walk_ff + PW'(rd_len) + PW'(1);
   assign extra_sum = extra_ff + (AW + 1)'(rd_len) + (AW + 1)'(1);
   assign absorb    = rd_mark && (rd_kind == KIND_FREE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (ctl.start) begin
               if (req.action == ACT_ALLOC) begin
                  state_in = S_A_WALK;
               end else if (req.frees_suppressed || hdr_bad) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_F_HEAD;
               end
            end
         end
         S_A_WALK: begin
            if (!rd_mark) begin
               state_in = S_DONE;
            end else if (fits) begin
               state_in = splits ? S_A_SPLIT : S_DONE;
            end else if (hop_pos >= HEAP_END) begin
               state_in = S_DONE;
            end
         end
         S_A_SPLIT: begin
            state_in = S_DONE;
         end
         S_F_HEAD: begin
            if (!rd_mark) begin
               state_in = S_DONE;
            end else if (hop_pos < HEAP_END) begin
               state_in = S_F_WALK;
            end else begin
               state_in = S_F_FINAL;
            end
         end
         S_F_WALK: begin
            if (!(absorb && (hop_walk < HEAP_END))) begin
               state_in = S_F_FINAL;
            end
         end
         S_F_FINAL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (ctl.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Memory accesses and datapath updates per state.
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = pos_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = pos_ff[AW-1:0];
      wr_data   = '0;
      clr_in    = clr_ff;
      pos_in    = pos_ff;
      walk_in   = walk_ff;
      need_in   = need_ff;
      kind_in   = kind_ff;
      len_in    = len_ff;
      extra_in  = extra_ff;
      res_in    = res_ff;
      sts.ready = (state_ff == S_IDLE);
      sts.done  = (state_ff == S_DONE) && ctl.slot_free;
      case (state_ff)
         S_CLEAR: begin
            // One entry per cycle: only block 0 holds a header spanning the heap.
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == '0) begin
               wr_data = {1'b1, KIND_FREE, LAST_IDX};
            end
            clr_in = clr_ff + AW'(1);
         end
         S_IDLE: begin
            if (ctl.start) begin
               need_in  = need_now;
               kind_in  = (req.block_kind == KIND_FREE) ? KIND_DEFAULT : req.block_kind;
               extra_in = '0;
               res_in   = '0;
               if (req.action == ACT_ALLOC) begin
                  pos_in  = '0;
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end else if (req.frees_suppressed) begin
                  res_in.status = ST_SUPP;
               end else if (hdr_bad) begin
                  res_in.status = ST_BAD;
               end else begin
                  pos_in  = hdr_now;
                  rd_en   = 1'b1;
                  rd_addr = hdr_now[AW-1:0];
               end
            end
         end
         S_A_WALK: begin
            if (!rd_mark) begin
               res_in.status = ST_FULL;
            end else if (fits) begin
               // Take this header; the remainder is written next cycle.
               wr_en                 = 1'b1;
               wr_data               = {1'b1, kind_ff, AW'(need_ff)};
               res_in.granted_handle = HANDLE_W'(pos_ff + PW'(1));
               res_in.status         = ST_OK;
               pos_in                = split_pos;
               len_in                = rd_len - AW'(need_ff) - AW'(1);
            end else if (hop_pos < HEAP_END) begin
               pos_in  = hop_pos;
               rd_en   = 1'b1;
               rd_addr = hop_pos[AW-1:0];
            end else begin
               res_in.status = ST_FULL;
            end
         end
         S_A_SPLIT: begin
            wr_en   = 1'b1;
            wr_data = {1'b1, KIND_FREE, len_ff};
         end
         S_F_HEAD: begin
            if (!rd_mark) begin
               res_in.status = ST_BAD;
            end else begin
               len_in  = rd_len;
               walk_in = hop_pos;
               if (hop_pos < HEAP_END) begin
                  rd_en   = 1'b1;
                  rd_addr = hop_pos[AW-1:0];
               end
            end
         end
         S_F_WALK: begin
            // Absorb a free neighbor and read the one after it.
            if (absorb) begin
               wr_en    = 1'b1;
               wr_addr  = walk_ff[AW-1:0];
               extra_in = extra_sum;
               walk_in  = hop_walk;
               if (hop_walk < HEAP_END) begin
                  rd_en   = 1'b1;
                  rd_addr = hop_walk[AW-1:0];
               end
            end
         end
         S_F_FINAL: begin
            wr_en                = 1'b1;
            wr_data              = {1'b1, KIND_FREE, len_ff + AW'(extra_ff)};
            res_in.status        = ST_OK;
            res_in.merged_blocks = MERGED_W'(extra_ff);
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      pos_ff   <= pos_in;
      walk_ff  <= walk_in;
      need_ff  <= need_in;
      kind_ff  <= kind_in;
      len_ff   <= len_in;
      extra_ff <= extra_in;
      res_ff   <= res_in;
   end

   assign res = res_ff;

endmodule

FILE: design/first_fit_block_allocator_unit.sv
// ============================================================================
// first_fit_block_allocator_unit
// An allocate walks the header chain from block 0; a split then writes the
// remainder header. A free reads the handle's header, absorbs the free headers
// that follow it, then writes the merged header. A suppressed free or a bad
// handle goes straight to the result; a free of a handle with no header below
// it stops after that read. One transaction at a time: the next is taken in the
// cycle after the result loads, and a stalled result delays that. The chain walk
// of up to HEAP_BLOCKS headers on the single read port sets the rate.
// Reset: a clearing pass over all HEAP_BLOCKS entries initializes the header
// memory; requests are stalled until it ends.
// ============================================================================
module first_fit_block_allocator_unit #(
   parameter int HEAP_BLOCKS = ffba_pkg::HEAP_BLOCKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffba_pkg::ffba_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffba_pkg::ffba_rsp_type rsp_data
);
   import ffba_pkg::*;

   ffba_ctl_type ctl;
   ffba_sts_type sts;
   ffba_rsp_type eng_res;
   logic         rsp_valid_ff, rsp_valid_in;
   ffba_rsp_type rsp_data_ff, rsp_data_in;

   // Request side: a transaction is taken whenever the engine is idle.
   assign req_stall     = !sts.ready;
   assign ctl.start     = req_valid && sts.ready;
   assign ctl.slot_free = !rsp_valid_ff || !rsp_stall;

   ffba_engine #(
      .HEAP_BLOCKS(HEAP_BLOCKS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .req  (req_data),
      .ctl  (ctl),
      .sts  (sts),
      .res  (eng_res)
   );

   // Result register: loaded when the engine finishes, held while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (sts.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/ffba_checker.sv
// ============================================================================
// ffba_checker
// Port-level checks of the allocator, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module ffba_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input ffba_pkg::ffba_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input ffba_pkg::ffba_rsp_type rsp_data
);
   import ffba_pkg::*;

   logic req_take;
   logic rsp_held;
   logic rsp_failed;
   logic rsp_payload;

   assign req_take = req_valid && !req_stall && (req_data.action == ACT_ALLOC
                     || req_data.action == ACT_FREE);

   // Helper terms that keep the assertions short.
   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_failed  = rsp_valid && (rsp_data.status != ST_OK);
   assign rsp_payload = (rsp_data.granted_handle != '0) || (rsp_data.merged_blocks != '0);

   // The engine works on one transaction at a time.
   `FFBA_ASSERT_PROP(a_busy_after_take, clock, reset, req_take |=> req_stall, "accepted while busy")

   // The clearing pass follows every reset.
   `FFBA_ASSERT_PROP(a_clear_after_reset, clock, reset, $fell(reset) |-> req_stall, "no clearing pass")

   // A stalled result holds.
   `FFBA_ASSERT_PROP(a_rsp_hold, clock, reset, rsp_held |=> (rsp_valid && $stable(rsp_data)), "held")

   // Only a successful transaction carries a handle or a merge count.
   `FFBA_ASSERT_NEVER(a_fields_vs_status, clock, reset, rsp_failed && rsp_payload, "payload on fail")

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);

FILE: bench/tb_first_fit_block_allocator_unit.sv
// ============================================================================
// tb_first_fit_block_allocator_unit
// Self-checking bench for the first-fit block allocator. A behavioral copy of
// the header chain predicts every result. Directed transactions cover the edge
// cases: heap full, exact fit, a zero-length split remainder, suppressed frees,
// bad handles, double frees and forward merging. Random fill and drain phases
// follow, with bursts of idle cycles on both channels.
// ============================================================================
module tb_first_fit_block_allocator_unit;
   import ffba_pkg::*;

   localparam int HEAP        = HEAP_BLOCKS_DEF;
   localparam int CYCLE_LIMIT = 3000000;

   logic         clock     = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   ffba_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   ffba_rsp_type rsp_data;

   // Bench-side copy of the header chain.
   bit                header_present [HEAP];
   logic [KIND_W-1:0] header_kind    [HEAP];
   int unsigned       header_length  [HEAP];

   ffba_rsp_type pending_outcomes [$];
   int           live_handles     [$];
   int           released_handles [$];
   bit           idling_on   = 1'b0;
   int           failures    = 0;
   int unsigned  cycle_count = 0;
   int           stall_left  = 0;

   first_fit_block_allocator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result channel back-pressure in random bursts.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Work out the result of one transaction and update the chain copy.
   function automatic ffba_rsp_type allocator_outcome(input ffba_req_type item);
      ffba_rsp_type      outcome;
      int unsigned       need, h, len, nxt, step, absorbed, rest;
      logic [KIND_W-1:0] kind;
      outcome = '0;
      if (item.action == ACT_ALLOC) begin
         need = item.request_bytes / BLOCK_BYTES + 1;
         kind = (item.block_kind == KIND_FREE) ? KIND_DEFAULT : item.block_kind;
         outcome.status = ST_FULL;
         h = 0;
         while (h < HEAP && header_present[h]) begin
            len = header_length[h];
            if (header_kind[h] == KIND_FREE && len >= need) begin
               // Split off the tail as a new free header unless the fit is exact.
               rest = h + need + 1;
               if (len > need && rest < HEAP) begin
                  header_present[rest] = 1'b1;
                  header_kind[rest]    = KIND_FREE;
                  header_length[rest]  = len - need - 1;
               end
               header_length[h] = need;
               header_kind[h]   = kind;
               outcome.granted_handle = HANDLE_W'(h + 1);
               outcome.status         = ST_OK;
               return outcome;
            end
            h = h + len + 1;
         end
      end else if (item.frees_suppressed) begin
         outcome.status = ST_SUPP;
      end else if (item.handle == 0 || !header_present[item.handle - 1]) begin
         outcome.status = ST_BAD;
      end else begin
         // Release the header, then absorb the free headers that follow it.
         h = item.handle - 1;
         header_kind[h] = KIND_FREE;
         absorbed = 0;
         nxt = h + header_length[h] + 1;
         while (nxt < HEAP && header_present[nxt] && header_kind[nxt] == KIND_FREE) begin
            step = header_length[nxt] + 1;
            absorbed += step;
            header_present[nxt] = 1'b0;
            header_length[nxt]  = 0;
            nxt += step;
         end
         header_length[h] += absorbed;
         outcome.status        = ST_OK;
         outcome.merged_blocks = MERGED_W'(absorbed);
      end
      return outcome;
   endfunction

   function automatic ffba_req_type alloc_request(input int bytes, input int kind);
      ffba_req_type item;
      item                  = ffba_req_type'({$urandom, $urandom});
      item.action           = ACT_ALLOC;
      item.request_bytes    = REQ_BYTES_W'(bytes);
      item.block_kind       = KIND_W'(kind);
      return item;
   endfunction

   function automatic ffba_req_type free_request(input int handle, input bit suppressed);
      ffba_req_type item;
      item                  = ffba_req_type'({$urandom, $urandom});
      item.action           = ACT_FREE;
      item.handle           = HANDLE_W'(handle);
      item.frees_suppressed = suppressed;
      return item;
   endfunction

   task automatic compare_field(input string name, input logic [MERGED_W-1:0] want,
                                input logic [MERGED_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // Check every accepted result against the oldest prediction.
   always @(posedge clock) begin : check_results
      ffba_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_outcomes.size() == 0) begin
            $error("result transaction with no prediction waiting: %h", rsp_data);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("granted_handle", want.granted_handle, rsp_data.granted_handle);
            compare_field("status", want.status, rsp_data.status);
            compare_field("merged_blocks", want.merged_blocks, rsp_data.merged_blocks);
         end
      end
   end

   // Present one transaction, wait for it to be taken, and predict its result.
   task automatic send_request(input ffba_req_type item, output ffba_rsp_type outcome);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_data  = item;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      outcome = allocator_outcome(item);
      pending_outcomes.push_back(outcome);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed_cases();
      ffba_rsp_type got;
      // Smallest allocate, then one larger than the whole heap.
      send_request(alloc_request(0, 1), got);
      send_request(alloc_request(8191, 15), got);
      // Kind zero is stored as the default kind.
      send_request(alloc_request(7, 0), got);
      send_request(alloc_request(8, 5), got);
      // Suppressed free of a live handle, then bad handles of each sort.
      send_request(free_request(3, 1'b1), got);
      send_request(free_request(0, 1'b0), got);
      send_request(free_request(4, 1'b0), got);
      send_request(free_request(1023, 1'b0), got);
      // Free with an allocated neighbor, then a second free of the same header.
      send_request(free_request(3, 1'b0), got);
      send_request(free_request(3, 1'b0), got);
      // Forward merges; the last one restores a single free header.
      send_request(free_request(5, 1'b0), got);
      send_request(free_request(1, 1'b0), got);
      // The absorbed header no longer exists.
      send_request(free_request(3, 1'b0), got);
      // Exact fit of the whole heap leaves nothing for the next allocate.
      send_request(alloc_request(8176, 9), got);
      send_request(alloc_request(0, 2), got);
      send_request(free_request(1, 1'b0), got);
      // A split that leaves a free header of length zero at the heap end.
      send_request(alloc_request(8168, 3), got);
      send_request(alloc_request(0, 4), got);
      send_request(free_request(1, 1'b0), got);
      send_request(alloc_request(8183, 7), got);
      send_request(free_request(1, 1'b0), got);
      wait_for_results();
   endtask

   // Random mix: mostly allocates while filling, mostly frees of live
   // handles while draining, plus stale, random and suppressed frees.
   task automatic run_churn(input int count, input bit filling);
      ffba_req_type item;
      ffba_rsp_type got;
      int           roll, live_idx, bytes;
      repeat (count) begin
         live_idx = -1;
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 62 : 22)) begin
            case ($urandom_range(0, 19))
               0:             bytes = $urandom_range(0, 8191);
               1, 2:          bytes = $urandom_range(512, 2047);
               3, 4, 5, 6, 7,
               8, 9:          bytes = $urandom_range(64, 511);
               default:       bytes = $urandom_range(0, 63);
            endcase
            item = alloc_request(bytes, $urandom_range(0, 15));
         end else if (roll < 88 && live_handles.size() != 0) begin
            live_idx = $urandom_range(0, live_handles.size() - 1);
            item = free_request(live_handles[live_idx], $urandom_range(0, 9) == 0);
         end else begin
            case ($urandom_range(0, 2))
               0: item = free_request($urandom_range(0, HEAP - 1), 1'b1);
               1: item = free_request($urandom_range(0, HEAP - 1), 1'b0);
               default: begin
                  if (released_handles.size() != 0) begin
                     item = free_request(
                        released_handles[$urandom_range(0, released_handles.size() - 1)],
                        1'b0);
                  end else begin
                     item = free_request($urandom_range(0, HEAP - 1), 1'b0);
                  end
               end
            endcase
         end
         send_request(item, got);
         // Track which handles are still held by the bench.
         if (item.action == ACT_ALLOC && got.status == ST_OK) begin
            live_handles.push_back(got.granted_handle);
         end else if (live_idx >= 0 && got.status == ST_OK) begin
            released_handles.push_back(live_handles[live_idx]);
            live_handles.delete(live_idx);
            if (released_handles.size() > 64) void'(released_handles.pop_front());
         end
      end
   endtask

   task automatic test_random_churn();
      for (int phase = 0; phase < 7; phase++) begin
         // One phase runs with no idling at all.
         idling_on = (phase != 2);
         run_churn(60, phase % 2 == 0);
         // Let the block go quiet once before carrying on.
         if (phase == 3) wait_for_results();
      end
   endtask

   task automatic test_steady_stream();
      idling_on = 1'b0;
      run_churn(70, 1'b1);
      run_churn(70, 1'b0);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      for (int i = 0; i < HEAP; i++) begin
         header_present[i] = 1'b0;
         header_kind[i]    = KIND_FREE;
         header_length[i]  = 0;
      end
      header_present[0] = 1'b1;
      header_length[0]  = HEAP - 1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      idling_on = 1'b1;
      test_random_churn();
      test_steady_stream();

      // Drain, then watch long enough to catch any stray result.
      wait_for_results();
      repeat (HEAP + 16) @(negedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/ffba_pkg.sv
design/ffba_engine.sv
design/first_fit_block_allocator_unit.sv
design/ffba_checker.sv
bench/tb_first_fit_block_allocator_unit.sv
